/* src/rbmpq_pkg.sv */
// ============================================================================
// rbmpq_pkg
// Shared types and codes for the row-bucket max-priority queue.
// ============================================================================
`default_nettype none

package rbmpq_pkg;

    // Operation codes carried in the input beat
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Fixed field widths of the channel payloads
    localparam int ITEM_BITS = 16;

    // Input beat
    typedef struct packed {
        logic                 operation;
        logic [ITEM_BITS-1:0] item_value;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [ITEM_BITS-1:0] removed_value;
        logic                 insert_rejected;
        logic                 queue_was_empty;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the accepted input beat
        logic scan_start;  // clear the tail scan
        logic scan_step;   // examine one row tail
        logic ins_commit;  // append to the accepting row, build result
        logic deq_commit;  // pop the winning row, request new tail
        logic tail_load;   // take new tail from the store read port
        logic out_load;    // move result into the output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_remove;   // captured beat is a removal
        logic scan_last;   // scan is on the last row
        logic need_read;   // popped row still holds entries
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

/* src/rbmpq_ram.sv */
// ============================================================================
// rbmpq_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module rbmpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/rbmpq_dpath.sv */
// ============================================================================
// rbmpq_dpath
// Queue datapath: per-row fill counts and tail registers, entry store,
// tail scan, insert search and the output register.
// ============================================================================
`default_nettype none

module rbmpq_dpath #(
    parameter int ROW_COUNT  = 8,
    parameter int ROW_DEPTH  = 8,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rbmpq_pkg::t_ctrl_cmd  i_cmd,
    output rbmpq_pkg::t_dp_status      o_status,
    input  wire rbmpq_pkg::t_in_item   i_in_data,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output rbmpq_pkg::t_out_item       o_out_data
);

    localparam int RB = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SB = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int FB = $clog2(ROW_DEPTH + 1);
    localparam int AW = RB + SB;
    localparam int MEM_DEPTH = 1 << AW;

    // row state
    logic [FB-1:0]         r_fill [ROW_COUNT];
    logic [VALUE_BITS-1:0] r_tail [ROW_COUNT];

    // captured beat
    logic                  r_op;
    logic [VALUE_BITS-1:0] r_val;

    // scan state
    logic [RB-1:0]         r_idx;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_best;
    logic [RB-1:0]         r_best_row;
    logic [FB-1:0]         r_best_fill;

    // result and output register
    rbmpq_pkg::t_out_item  r_res;
    rbmpq_pkg::t_out_item  r_out;
    logic                  r_out_valid;

    // insert search
    logic                  hit;
    logic [RB-1:0]         hit_row;
    logic [FB-1:0]         hit_fill;

    // scan selection
    logic [FB-1:0]         sel_fill;
    logic [VALUE_BITS-1:0] sel_tail;
    logic                  sel_wins;

    // store ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    // capture input beat, value cut or extended to the storage width
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_data.operation;
            r_val <= VALUE_BITS'(i_in_data.item_value);
        end
    end

    // lowest row that is not full and is empty or has a smaller tail
    always_comb begin
        hit      = 1'b0;
        hit_row  = '0;
        hit_fill = '0;
        for (int r = ROW_COUNT - 1; r >= 0; r--) begin
            if (r_fill[r] < FB'(ROW_DEPTH) &&
                (r_fill[r] == '0 || r_tail[r] < r_val)) begin
                hit      = 1'b1;
                hit_row  = RB'(r);
                hit_fill = r_fill[r];
            end
        end
    end

    // one row per scan cycle; strict compare keeps the lowest row on ties
    assign sel_fill = r_fill[r_idx];
    assign sel_tail = r_tail[r_idx];
    assign sel_wins = (sel_fill != '0) && (!r_found || sel_tail > r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_cmd.scan_start) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + RB'(1);
            if (sel_wins) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && sel_wins) begin
            r_best      <= sel_tail;
            r_best_row  <= r_idx;
            r_best_fill <= sel_fill;
        end
    end

    // fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_fill[r] <= '0;
            end
        end else if (i_cmd.ins_commit && hit) begin
            r_fill[hit_row] <= hit_fill + FB'(1);
        end else if (i_cmd.deq_commit && r_found) begin
            r_fill[r_best_row] <= r_best_fill - FB'(1);
        end
    end

    // tail registers follow the last entry of each row
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_commit && hit) begin
            r_tail[hit_row] <= r_val;
        end else if (i_cmd.tail_load) begin
            r_tail[r_best_row] <= ram_rdata;
        end
    end

    // entry store: rows at {row, slot}
    assign ram_we    = i_cmd.ins_commit && hit;
    assign ram_waddr = {hit_row, SB'(hit_fill)};
    assign ram_raddr = {r_best_row, SB'(r_best_fill - FB'(2))};

    rbmpq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_re    (i_cmd.deq_commit),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result of the current operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_commit) begin
            r_res.removed_value   <= '0;
            r_res.insert_rejected <= !hit;
            r_res.queue_was_empty <= 1'b0;
        end else if (i_cmd.deq_commit) begin
            r_res.removed_value   <= r_found ? (rbmpq_pkg::ITEM_BITS)'(r_best) : '0;
            r_res.insert_rejected <= 1'b0;
            r_res.queue_was_empty <= !r_found;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status
    assign o_status.is_remove = (r_op == rbmpq_pkg::OP_REMOVE);
    assign o_status.scan_last = (r_idx == RB'(ROW_COUNT - 1));
    assign o_status.need_read = r_found && (r_best_fill > FB'(1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // a result never carries both flags
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.insert_rejected && r_out.queue_was_empty))
        else $error("rejected and empty flags both set");

    // an empty dequeue returns zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.queue_was_empty |-> r_out.removed_value == '0)
        else $error("empty dequeue returned a value");

    // a loaded result is presented next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* src/rbmpq_ctrl.sv */
// ============================================================================
// rbmpq_ctrl
// Operation sequencer: accept, insert or tail scan, pop, tail refill, result.
// ============================================================================
`default_nettype none

module rbmpq_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire rbmpq_pkg::t_dp_status i_status,
    output rbmpq_pkg::t_ctrl_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEQ  = 3'd3;
    localparam logic [2:0] S_RDW  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_INS;
                end
            end
            S_INS: begin
                if (i_status.is_remove) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.ins_commit = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DEQ;
                end
            end
            S_DEQ: begin
                o_cmd.deq_commit = 1'b1;
                n_state          = i_status.need_read ? S_RDW : S_DONE;
            end
            S_RDW: begin
                o_cmd.tail_load = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // at most one state-changing command per cycle
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.ins_commit, o_cmd.deq_commit, o_cmd.tail_load, o_cmd.out_load}))
        else $error("conflicting commands");

    // tail refill only right after a pop
    a_rdw_after_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RDW |-> $past(r_state) == S_DEQ)
        else $error("tail refill without pop");

    // an accepted beat starts work
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == S_INS)
        else $error("accepted beat not started");

endmodule

`default_nettype wire

/* src/row_bucket_max_priority_queue.sv */
// ============================================================================
// row_bucket_max_priority_queue
// Max-priority queue kept as rows of ascending runs, one beat in, one out.
// ============================================================================
// One operation is in flight at a time. An insert runs from accept through a
// parallel search of all row tails with append to its result. After the
// accept, a removal clears the tail scan, the row tails are then compared one
// row per cycle, the winner is popped, and, when the popped row still holds
// entries, the new tail comes through the entry store's registered read port.
// The finished result sits in an output register, so a waiting result does
// not hold back the next accept. No clearing pass runs after reset.
`default_nettype none

module row_bucket_max_priority_queue #(
    parameter int ROW_COUNT  = 8,
    parameter int ROW_DEPTH  = 8,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire rbmpq_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rbmpq_pkg::t_out_item      o_out_data
);

    rbmpq_pkg::t_ctrl_cmd  cmd;
    rbmpq_pkg::t_dp_status status;

    // sequencer
    rbmpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    rbmpq_dpath #(
        .ROW_COUNT  (ROW_COUNT),
        .ROW_DEPTH  (ROW_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
// ============================================================================
// tb
// Self-checking bench for the row-bucket max-priority queue. A directed table
// walks the empty, equal-value, full-row and rejection corners, then bursts of
// ascending runs, random inserts, removals and full drains run under four
// idling phases. Every result beat is checked against the table or a shadow queue model.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int NUM_ROWS       = 8;
    localparam int ROW_SLOTS      = 8;
    localparam int VAL_BITS       = rbmpq_pkg::ITEM_BITS;
    localparam int REMOVE_LATENCY = NUM_ROWS + 5;
    localparam int RANDOM_ITEMS   = 456;   // per idling phase

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        rbmpq_pkg::t_in_item  beat;
        bit                   typed;
        rbmpq_pkg::t_out_item want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    rbmpq_pkg::t_in_item  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    rbmpq_pkg::t_out_item o_out_data;

    // Shadow copy of the rows
    logic [VAL_BITS-1:0] bucket_vals [NUM_ROWS][ROW_SLOTS];
    int unsigned         bucket_fill [NUM_ROWS];

    rbmpq_pkg::t_out_item pending_results [$];
    t_dir_row             dir_rows [$];
    int unsigned in_idle_pct  = 0;
    int unsigned out_stall_pct = 0;
    int unsigned fail_count   = 0;

    row_bucket_max_priority_queue #(
        .ROW_COUNT  (NUM_ROWS),
        .ROW_DEPTH  (ROW_SLOTS),
        .VALUE_BITS (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Apply one operation to the shadow queue and return its result
    function automatic rbmpq_pkg::t_out_item queue_op_result(rbmpq_pkg::t_in_item beat);
        rbmpq_pkg::t_out_item res;
        int                   r;
        int unsigned          n;
        bit                   found;
        int                   best_row;
        logic [VAL_BITS-1:0]  best;
        res      = '0;
        found    = 1'b0;
        best_row = 0;
        best     = '0;
        if (beat.operation == rbmpq_pkg::OP_INSERT) begin
            // first open row that is empty or has a strictly smaller tail
            res.insert_rejected = 1'b1;
            for (r = 0; r < NUM_ROWS && res.insert_rejected; r++) begin
                n = bucket_fill[r];
                if (n < ROW_SLOTS && (n == 0 || bucket_vals[r][n-1] < beat.item_value)) begin
                    bucket_vals[r][n]   = beat.item_value;
                    bucket_fill[r]      = n + 1;
                    res.insert_rejected = 1'b0;
                end
            end
        end else begin
            // largest tail wins, lowest row on ties
            for (r = 0; r < NUM_ROWS; r++) begin
                n = bucket_fill[r];
                if (n != 0 && (!found || bucket_vals[r][n-1] > best)) begin
                    found    = 1'b1;
                    best_row = r;
                    best     = bucket_vals[r][n-1];
                end
            end
            if (!found) begin
                res.queue_was_empty = 1'b1;
            end else begin
                bucket_fill[best_row] = bucket_fill[best_row] - 1;
                res.removed_value     = best;
            end
        end
        return res;
    endfunction

    function automatic int unsigned queued_total();
        int unsigned sum;
        sum = 0;
        foreach (bucket_fill[r]) sum += bucket_fill[r];
        return sum;
    endfunction

    function automatic rbmpq_pkg::t_in_item make_beat(logic op, logic [VAL_BITS-1:0] value);
        rbmpq_pkg::t_in_item beat;
        beat.operation  = op;
        beat.item_value = value;
        return beat;
    endfunction

    function automatic void add_dir_row(logic op, logic [VAL_BITS-1:0] value, bit typed,
                                        logic [VAL_BITS-1:0] removed, logic rejected,
                                        logic was_empty);
        t_dir_row row;
        row.beat                 = make_beat(op, value);
        row.typed                = typed;
        row.want.removed_value   = removed;
        row.want.insert_rejected = rejected;
        row.want.queue_was_empty = was_empty;
        dir_rows.push_back(row);
    endfunction

    // Mix of extremes, tightly packed small and large values and full range
    function automatic logic [VAL_BITS-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            1: return VAL_BITS'($urandom_range(0, 15));
            2: return VAL_BITS'($urandom_range(16'hFF00, 16'hFFFF));
            default: return VAL_BITS'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [VAL_BITS-1:0] any_value();
        return VAL_BITS'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("tb: %s", msg);
    endfunction

    // Drive one input beat, with random idle cycles ahead of it
    task automatic send_beat(rbmpq_pkg::t_in_item beat, bit typed,
                             rbmpq_pkg::t_out_item want);
        rbmpq_pkg::t_out_item predicted;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        predicted = queue_op_result(beat);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_op(logic op, logic [VAL_BITS-1:0] value);
        send_beat(make_beat(op, value), 1'b0, '0);
    endtask

    // Bursts of well-formed traffic with some noise mixed in
    task automatic run_random_traffic(int unsigned target);
        int unsigned         sent;
        int unsigned         kind;
        int unsigned         len;
        int unsigned         k;
        int unsigned         step;
        logic [VAL_BITS-1:0] v;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 19);
            len  = $urandom_range(1, 10);
            if (kind < 7) begin
                // ascending run, fills rows deeply
                v    = ($urandom_range(0, 2) == 0) ? pick_value()
                                                   : VAL_BITS'($urandom_range(0, 255));
                step = (kind < 3) ? $urandom_range(1, 3) : $urandom_range(1, 4096);
                for (k = 0; k < len; k++) begin
                    send_op(rbmpq_pkg::OP_INSERT, v);
                    sent++;
                    if (v > 16'hFFFF - step) break;
                    v = v + VAL_BITS'(step);
                end
            end else if (kind < 10) begin
                for (k = 0; k < len; k++) begin
                    send_op(rbmpq_pkg::OP_INSERT, pick_value());
                    sent++;
                end
            end else if (kind == 10) begin
                // repeated value: tails equal to it must refuse
                v = pick_value();
                for (k = 0; k < (len % 4) + 2; k++) begin
                    send_op(rbmpq_pkg::OP_INSERT, v);
                    sent++;
                end
            end else if (kind == 11) begin
                for (k = 0; k < len; k++) begin
                    send_op(($urandom_range(0, 1) != 0) ? rbmpq_pkg::OP_REMOVE
                                                        : rbmpq_pkg::OP_INSERT,
                            any_value());
                    sent++;
                end
            end else if (kind == 12) begin
                // drain to empty, then hit the empty queue
                while (queued_total() > 0) begin
                    send_op(rbmpq_pkg::OP_REMOVE, any_value());
                    sent++;
                end
                len = $urandom_range(1, 2);
                for (k = 0; k < len; k++) begin
                    send_op(rbmpq_pkg::OP_REMOVE, any_value());
                    sent++;
                end
            end else begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    send_op(rbmpq_pkg::OP_REMOVE, any_value());
                    sent++;
                end
            end
        end
    endtask

    // Result side: check accepted beats, then pick the next stall
    always @(posedge i_clk) begin
        rbmpq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result beat %p with nothing pending", o_out_data));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.removed_value !== want.removed_value ||
                    o_out_data.insert_rejected !== want.insert_rejected ||
                    o_out_data.queue_was_empty !== want.queue_was_empty) begin
                    note_failure($sformatf(
                        "mismatch: expected val=%h rej=%b empty=%b, got val=%h rej=%b empty=%b",
                        want.removed_value, want.insert_rejected, want.queue_was_empty,
                        o_out_data.removed_value, o_out_data.insert_rejected,
                        o_out_data.queue_was_empty));
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Stimulus
    initial begin
        int unsigned phase;
        int unsigned i;

        foreach (bucket_fill[r]) bucket_fill[r] = 0;

        // empty queue, eight zeros spread over all rows, then a refused zero
        add_dir_row(rbmpq_pkg::OP_REMOVE, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b1);
        for (i = 0; i < NUM_ROWS; i++) begin
            add_dir_row(rbmpq_pkg::OP_INSERT, 16'h0000, 1'b1, '0, 1'b0, 1'b0);
        end
        add_dir_row(rbmpq_pkg::OP_INSERT, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
        // equal tails refuse, tie on removal goes to the lowest row
        add_dir_row(rbmpq_pkg::OP_INSERT, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_dir_row(rbmpq_pkg::OP_INSERT, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_dir_row(rbmpq_pkg::OP_INSERT, 16'h8000, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_dir_row(rbmpq_pkg::OP_REMOVE, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 1'b0);
        add_dir_row(rbmpq_pkg::OP_REMOVE, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 1'b0);
        add_dir_row(rbmpq_pkg::OP_REMOVE, 16'hFFFF, 1'b1, 16'h8000, 1'b0, 1'b0);
        // fill row 0 to the top, next value spills to a later row
        for (i = 1; i < ROW_SLOTS; i++) begin
            add_dir_row(rbmpq_pkg::OP_INSERT, VAL_BITS'(i), 1'b0, '0, 1'b0, 1'b0);
        end
        add_dir_row(rbmpq_pkg::OP_INSERT, 16'h0064, 1'b0, '0, 1'b0, 1'b0);
        add_dir_row(rbmpq_pkg::OP_REMOVE, 16'h5555, 1'b0, '0, 1'b0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 61; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 61; end
                default: begin in_idle_pct = 37; out_stall_pct = 37; end
            endcase
            run_random_traffic(RANDOM_ITEMS);
            // hold off until every result of this phase is back
            i_in_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end

        out_stall_pct = 0;
        repeat (REMOVE_LATENCY * 2) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
